### sv/pbil_pkg.sv
// ----------------------------------------------------------------------------
// pbil_pkg
// Shared types and constants of the incremental learning engine.
// ----------------------------------------------------------------------------
package pbil_pkg;

    localparam logic [15:0] PROB_HALF = 16'h8000;
    localparam logic [15:0] PROB_ONE  = 16'hFFFF;

    localparam logic [1:0] REG_MUTATION   = 2'd0;
    localparam logic [1:0] REG_ADAPTATION = 2'd1;
    localparam logic [1:0] REG_SEED       = 2'd2;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_REPORT  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic take;         // latch request fields
        logic samp_start;   // clear sample walk
        logic samp_step;    // one gene draw
        logic report;       // record fitness, best, advance slot
        logic set_work;     // working slot = slot counter
        logic scan_start;
        logic scan_step;    // one population member compared
        logic adapt_start;
        logic adapt_step;   // one gene adapted
        logic mut_start;
        logic mut_step;     // one gene mutated
        logic out_load;     // capture result
        logic done;
    } pbil_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic slot_zero;    // slot counter is zero
        logic walk_last;    // sample walk at last gene of last slot
        logic scan_last;
        logic gene_last;
    } pbil_sts_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

### sv/pbil_ctrl.sv
// ----------------------------------------------------------------------------
// pbil_ctrl
// Sequencer: sampling walk, report, fittest search, adaptation, mutation.
// ----------------------------------------------------------------------------
module pbil_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                out_free,
    input  pbil_pkg::pbil_sts_t sts,
    output logic                busy,
    output pbil_pkg::pbil_cmd_t cmd
);
    import pbil_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEC    = 3'd1;
    localparam logic [2:0] S_SAMP   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_ADAPT  = 3'd4;
    localparam logic [2:0] S_MUT    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       gen_reg, gen_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            gen_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb begin
        state_next = state_reg;
        gen_next   = gen_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.take   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                gen_next = 1'b0;
                if (sts.func == FUNC_REQUEST) begin
                    if (sts.slot_zero) begin
                        cmd.samp_start = 1'b1;
                        state_next     = S_SAMP;
                    end else begin
                        cmd.set_work = 1'b1;
                        state_next   = S_OUT;
                    end
                end else begin
                    cmd.report = 1'b1;
                    // report leaves counter at zero after the last slot
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SAMP: begin
                cmd.samp_step = 1'b1;
                if (sts.walk_last) begin
                    state_next = S_OUT;
                end
            end
            S_SCAN: begin
                if (!sts.slot_zero) begin
                    state_next = S_OUT;
                end else begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_last) begin
                        cmd.adapt_start = 1'b1;
                        state_next      = S_ADAPT;
                    end
                end
            end
            S_ADAPT: begin
                cmd.adapt_step = 1'b1;
                if (sts.gene_last) begin
                    cmd.mut_start = 1'b1;
                    state_next    = S_MUT;
                end
            end
            S_MUT: begin
                cmd.mut_step = 1'b1;
                if (sts.gene_last) begin
                    gen_next   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.done     = gen_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_SAMP && sts.walk_last) begin
            cmd.set_work = 1'b1;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> !busy)
        else $error("result load did not return to idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> !busy)
        else $error("item taken while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mut_step |-> !cmd.adapt_step && !cmd.samp_step)
        else $error("gene walks overlap");

endmodule

### sv/pbil_dp.sv
// ----------------------------------------------------------------------------
// pbil_dp
// Datapath: probabilities, population memories, best tracking, generator.
// ----------------------------------------------------------------------------
module pbil_dp #(
    parameter int POP_SIZE   = 16,
    parameter int GENE_COUNT = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pbil_pkg::pbil_cmd_t cmd,
    output pbil_pkg::pbil_sts_t sts,
    input  logic                in_func,
    input  logic [31:0]         in_fitness,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_idx,
    input  logic [31:0]         cfg_data,
    output logic [15:0]         mut_rate,
    output logic [15:0]         adapt_rate,
    output logic [31:0]         seed,
    output logic [31:0]         o_chrom,
    output logic [3:0]          o_slot,
    output logic [31:0]         o_best_fit,
    output logic [31:0]         o_best_genes
);
    import pbil_pkg::*;

    localparam int SW = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
    localparam int GW = (GENE_COUNT > 1) ? $clog2(GENE_COUNT) : 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(POP_SIZE - 1);
    localparam logic [GW-1:0] GENE_LAST = GW'(GENE_COUNT - 1);

    logic [15:0]           prob_reg [GENE_COUNT];
    logic [GENE_COUNT-1:0] genes_reg [POP_SIZE];
    logic signed [31:0]    fit_reg [POP_SIZE];
    logic signed [31:0]    best_reg;
    logic [GENE_COUNT-1:0] best_genes_reg;
    logic [SW-1:0]         slot_reg, work_reg;
    logic [31:0]           rnd_reg;
    logic [15:0]           mut_reg, adapt_reg;
    logic [31:0]           seed_reg;
    logic                  func_reg;
    logic signed [31:0]    fitin_reg;
    logic [SW-1:0]         wslot_reg, walk_slot_reg;
    logic [GW-1:0]         gene_reg;
    logic [GENE_COUNT-1:0] acc_reg;
    logic [SW-1:0]         scan_reg, fittest_reg;
    logic signed [31:0]    high_reg;
    logic [GENE_COUNT-1:0] fgenes_reg;

    logic [31:0] rnd_next;
    logic [15:0] r16, p_cur;
    logic [31:0] prod;
    logic [15:0] p_adapt;
    logic [SW-1:0] slot_inc;
    logic [GENE_COUNT-1:0] gene_bit;

    assign rnd_next = xorshift32(rnd_reg);
    assign r16      = rnd_next[31:16];
    assign p_cur    = prob_reg[gene_reg];
    assign prod     = {16'd0, adapt_reg} *
                      {16'd0, (fgenes_reg[gene_reg] ? (PROB_ONE - p_cur) : p_cur)};
    assign p_adapt  = fgenes_reg[gene_reg] ? (p_cur + prod[31:16]) : (p_cur - prod[31:16]);
    assign slot_inc = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
    assign gene_bit = {{(GENE_COUNT-1){1'b0}}, 1'b1} << gene_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mut_reg   <= 16'd20;
            adapt_reg <= 16'd6554;
            seed_reg  <= 32'd1;
            rnd_reg   <= 32'd1;
            for (int j = 0; j < GENE_COUNT; j++) prob_reg[j] <= PROB_HALF;
            for (int i = 0; i < POP_SIZE; i++) begin
                genes_reg[i] <= '0;
                fit_reg[i]   <= '0;
            end
            best_reg       <= 32'sh80000000;
            best_genes_reg <= '0;
            slot_reg       <= '0;
            work_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_MUTATION:   mut_reg <= cfg_data[15:0];
                    REG_ADAPTATION: adapt_reg <= cfg_data[15:0];
                    REG_SEED: begin
                        seed_reg <= cfg_data;
                        rnd_reg  <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
                    end
                    default: ;
                endcase
            end
            if (cmd.set_work) work_reg <= slot_reg;
            if (cmd.samp_start) begin
                for (int i = 0; i < POP_SIZE; i++) fit_reg[i] <= '0;
            end
            if (cmd.samp_step) begin
                rnd_reg <= rnd_next;
                if (gene_reg == GENE_LAST) begin
                    genes_reg[walk_slot_reg] <= acc_reg |
                        ((r16 <= p_cur) ? gene_bit : '0);
                end
            end
            if (cmd.report) begin
                slot_reg       <= slot_inc;
                fit_reg[work_reg] <= fitin_reg;
                if (fitin_reg > best_reg) begin
                    best_reg       <= fitin_reg;
                    best_genes_reg <= genes_reg[work_reg];
                end
            end
            if (cmd.adapt_step) prob_reg[gene_reg] <= p_adapt;
            if (cmd.mut_step) begin
                rnd_reg <= rnd_next;
                if (r16 < mut_reg) prob_reg[gene_reg] <= PROB_HALF;
            end
        end
    end

    // walk counters, no reset needed beyond the start commands
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            func_reg  <= in_func;
            fitin_reg <= in_fitness;
        end
        if (cmd.samp_start || cmd.adapt_start || cmd.mut_start) begin
            gene_reg      <= '0;
            walk_slot_reg <= '0;
            acc_reg       <= '0;
        end else if (cmd.samp_step) begin
            if (gene_reg == GENE_LAST) begin
                gene_reg      <= '0;
                walk_slot_reg <= walk_slot_reg + 1'b1;
                acc_reg       <= '0;
            end else begin
                gene_reg <= gene_reg + 1'b1;
                acc_reg  <= acc_reg | ((r16 <= p_cur) ? gene_bit : '0);
            end
        end else if (cmd.adapt_step || cmd.mut_step) begin
            gene_reg <= gene_reg + 1'b1;
        end
        if (cmd.scan_start) begin
            scan_reg    <= '0;
            fittest_reg <= '0;
            high_reg    <= '0;
        end else if (cmd.scan_step) begin
            scan_reg <= scan_reg + 1'b1;
            if (fit_reg[scan_reg] > high_reg) begin
                high_reg    <= fit_reg[scan_reg];
                fittest_reg <= scan_reg;
                if (scan_reg == SLOT_LAST) fgenes_reg <= genes_reg[scan_reg];
            end else if (scan_reg == SLOT_LAST) begin
                fgenes_reg <= genes_reg[fittest_reg];
            end
        end
        wslot_reg <= work_reg;
    end

    assign sts.func      = func_reg;
    assign sts.slot_zero = (slot_reg == '0);
    assign sts.walk_last = (walk_slot_reg == SLOT_LAST) && (gene_reg == GENE_LAST);
    assign sts.scan_last = (scan_reg == SLOT_LAST);
    assign sts.gene_last = (gene_reg == GENE_LAST);

    assign mut_rate     = mut_reg;
    assign adapt_rate   = adapt_reg;
    assign seed         = seed_reg;
    assign o_chrom      = 32'(genes_reg[work_reg]);
    assign o_slot       = 4'(work_reg);
    assign o_best_fit   = best_reg;
    assign o_best_genes = 32'(best_genes_reg);

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.report |=> (best_reg >= $past(fitin_reg)) || ($past(fitin_reg) == 32'sh80000000))
        else $error("best fitness below report");
    assert property (@(posedge aclk) disable iff (!aresetn)
        rnd_reg != 32'd0)
        else $error("generator stuck at zero");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.report |=> wslot_reg == $past(work_reg))
        else $error("working slot moved on report");

endmodule

### sv/pbil_optimizer_engine_unit.sv
// ----------------------------------------------------------------------------
// pbil_optimizer_engine_unit
// Population-based incremental learning engine, top level.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser = func (0 request chromosome, 1 report fitness),
// tdata = fitness. One result on m_axis for every input item.
// A request with the slot counter at zero samples the population first:
// one draw per gene per member. The report that closes a generation also
// runs the fittest search, then adaptation and mutation, one gene a cycle
// through one multiplier.
// The block takes one item at a time; s_axis_tready is low while it works.
// The result waits in the output register while m_axis_tready is low; the
// next item is accepted meanwhile and holds before its own result load.
// Reset (aresetn low, synchronous) restores all probabilities to one half,
// clears the population and best record, and reloads registers to defaults.
// APB: 0x0 mutation_rate, 0x4 adaptation_rate, 0x8 random_seed.
// ----------------------------------------------------------------------------
module pbil_optimizer_engine_unit #(
    parameter int POP_SIZE   = 16,
    parameter int GENE_COUNT = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // fitness[31:0]
    input  logic         s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // chromosome[31:0], slot_index[35:32], best_fitness[67:36],
    // best_genes[99:68], generation_done[100], zero fill [103:101]
    output logic [103:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import pbil_pkg::*;

    pbil_cmd_t   cmd;
    pbil_sts_t   sts;
    logic        busy, in_fire, cfg_we, out_free;
    logic [15:0] mut_rate, adapt_rate;
    logic [31:0] seed, chrom, bfit, bgenes;
    logic [3:0]  slot;
    logic [103:0] out_reg;
    logic        vld_reg;

    assign pready        = 1'b1;
    assign cfg_we        = psel && penable && pwrite;
    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !vld_reg || m_axis_tready;

    always_comb begin
        case (paddr[3:2])
            REG_MUTATION:   prdata = {16'd0, mut_rate};
            REG_ADAPTATION: prdata = {16'd0, adapt_rate};
            REG_SEED:       prdata = seed;
            default:        prdata = 32'd0;
        endcase
    end

    pbil_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_free(out_free),
        .sts(sts), .busy(busy), .cmd(cmd)
    );

    pbil_dp #(.POP_SIZE(POP_SIZE), .GENE_COUNT(GENE_COUNT)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_func(s_axis_tuser), .in_fitness(s_axis_tdata),
        .cfg_we(cfg_we), .cfg_idx(paddr[3:2]), .cfg_data(pwdata),
        .mut_rate(mut_rate), .adapt_rate(adapt_rate), .seed(seed),
        .o_chrom(chrom), .o_slot(slot), .o_best_fit(bfit), .o_best_genes(bgenes)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (cmd.out_load) begin
            vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= {3'd0, cmd.done, bgenes, bfit, slot, chrom};
        end
    end

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = out_reg;

endmodule

### test/pbil_optimizer_engine_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbil_optimizer_engine_checker
// Watches the request, result and register ports of the learning engine,
// predicts every result from its own copy of the engine state and compares
// each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pbil_optimizer_engine_checker
    import pbil_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending_count,
    output int           result_count,
    output int           gen_count
);

    typedef struct packed {
        logic        gen_done;
        logic [31:0] best_genes;
        logic [31:0] best_fit;
        logic [3:0]  slot;
        logic [31:0] chrom;
    } engine_result_t;

    logic [15:0]        prob [32];
    logic [31:0]        pop_genes [16];
    logic signed [31:0] pop_fit [16];
    logic signed [31:0] best_score;
    logic [31:0]        best_chrom;
    logic [3:0]         slot_ctr;
    logic [3:0]         work_slot;
    logic [31:0]        rng;
    logic [15:0]        mut_rate;
    logic [15:0]        adapt_rate;

    engine_result_t expected_results [$];

    function automatic logic [15:0] next_draw();
        rng = rng ^ (rng << 13);
        rng = rng ^ (rng >> 17);
        rng = rng ^ (rng << 5);
        return rng[31:16];
    endfunction

    function automatic void sample_generation();
        for (int i = 0; i < 16; i++) begin
            pop_fit[i] = 0;
            pop_genes[i] = '0;
            for (int j = 0; j < 32; j++)
                if (next_draw() <= prob[j]) pop_genes[i][j] = 1'b1;
        end
    endfunction

    function automatic void learn_generation();
        logic signed [31:0] top;
        int                 fittest;
        logic [31:0]        prod;
        top = 0;
        fittest = 0;
        for (int i = 0; i < 16; i++)
            if (pop_fit[i] > top) begin
                top = pop_fit[i];
                fittest = i;
            end
        for (int j = 0; j < 32; j++) begin
            if (pop_genes[fittest][j]) begin
                prod = adapt_rate * (PROB_ONE - prob[j]);
                prob[j] = prob[j] + prod[31:16];
            end else begin
                prod = adapt_rate * prob[j];
                prob[j] = prob[j] - prod[31:16];
            end
        end
        for (int j = 0; j < 32; j++)
            if (next_draw() < mut_rate) prob[j] = PROB_HALF;
    endfunction

    function automatic engine_result_t predict_engine(logic fn, logic [31:0] fit);
        engine_result_t r;
        r.gen_done = 1'b0;
        if (fn == FUNC_REQUEST) begin
            if (slot_ctr == 0) sample_generation();
            work_slot = slot_ctr;
        end else begin
            slot_ctr = slot_ctr + 4'd1;
            pop_fit[work_slot] = fit;
            if ($signed(fit) > best_score) begin
                best_score = fit;
                best_chrom = pop_genes[work_slot];
            end
            if (slot_ctr == 0) begin
                learn_generation();
                r.gen_done = 1'b1;
            end
        end
        r.chrom = pop_genes[work_slot];
        r.slot = work_slot;
        r.best_fit = best_score;
        r.best_genes = best_chrom;
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        engine_result_t got;
        engine_result_t want;
        if (!aresetn) begin
            for (int j = 0; j < 32; j++) prob[j] <= PROB_HALF;
            for (int i = 0; i < 16; i++) begin
                pop_genes[i] <= '0;
                pop_fit[i] <= 0;
            end
            best_score <= 32'sh8000_0000;
            best_chrom <= '0;
            slot_ctr <= '0;
            work_slot <= '0;
            rng <= 32'd1;
            mut_rate <= 16'd20;
            adapt_rate <= 16'd6554;
            expected_results = {};
            fail_count <= 0;
            result_count <= 0;
            gen_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MUTATION:   mut_rate = pwdata[15:0];
                    REG_ADAPTATION: adapt_rate = pwdata[15:0];
                    REG_SEED:       rng = (pwdata == 0) ? 32'd1 : pwdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_engine(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[100:0];
                result_count <= result_count + 1;
                if (got.gen_done) gen_count <= gen_count + 1;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || m_axis_tdata[103:101] !== 3'b0) begin
                        if (fail_count < 10)
                            $display({"mismatch: chrom %h/%h slot %0d/%0d best %h/%h ",
                                      "genes %h/%h done %b/%b"},
                                     want.chrom, got.chrom, want.slot, got.slot,
                                     want.best_fit, got.best_fit, want.best_genes,
                                     got.best_genes, want.gen_done, got.gen_done);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### test/pbil_optimizer_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbil_optimizer_engine_unit_tb
// Drives requests and fitness reports into the learning engine with random
// bursts, gaps and result stalls, across several register settings.
// ----------------------------------------------------------------------------
module pbil_optimizer_engine_unit_tb;
    import pbil_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 400;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending_count;
    int           result_count;
    int           gen_count;
    int           idle_cycles = 0;
    logic         hold_req = 1'b0;
    logic         hold_done = 1'b0;
    int           hold_cnt = 0;
    int           sent = 0;

    always #1 aclk = ~aclk;

    pbil_optimizer_engine_unit uut (.*);

    pbil_optimizer_engine_checker checker_i (.*);

    // receiver: own stall pattern, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            case (($urandom_range(0, 99) < 3) ? 2 : (sent / 200) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results pending", pending_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_item(logic fn, logic [31:0] fit);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= fn;
        s_axis_tdata <= fit;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sent++;
        if ($urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_fitness();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    // one generation: request/report pairs with random content
    task automatic run_generation();
        for (int k = 0; k < 16; k++) begin
            send_item(FUNC_REQUEST, $urandom);
            send_item(FUNC_REPORT, rand_fitness());
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, repeated request, report without request, extremes
        send_item(FUNC_REQUEST, 32'hFFFF_FFFF);
        send_item(FUNC_REQUEST, 32'h0);
        send_item(FUNC_REPORT, 32'h8000_0000);
        send_item(FUNC_REPORT, 32'h7FFF_FFFF);
        send_item(FUNC_REPORT, 32'hFFFF_FFFF);
        for (int k = 0; k < 7; k++) send_item(FUNC_REPORT, k);
        for (int k = 0; k < 6; k++) begin
            send_item(FUNC_REQUEST, 32'h5555_5555);
            send_item(FUNC_REPORT, 32'h8000_0001 + k);
        end
        drain();

        reg_write(REG_MUTATION, 16'hFFFF);
        reg_write(REG_ADAPTATION, 16'hFFFF);
        reg_write(REG_SEED, 32'h0);
        reg_write(2'd3, 32'hDEAD_BEEF);
        run_generation();
        // long receiver hold-off while the sender keeps offering
        hold_req <= 1'b1;
        run_generation();
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin reg_write(REG_MUTATION, 0); reg_write(REG_ADAPTATION, 0); end
                1: begin reg_write(REG_MUTATION, 20); reg_write(REG_ADAPTATION, 65535); end
                2: begin reg_write(REG_MUTATION, 65535); reg_write(REG_ADAPTATION, 6554); end
                default: begin
                    reg_write(REG_MUTATION, $urandom_range(0, 2000));
                    reg_write(REG_ADAPTATION, $urandom_range(0, 65535));
                end
            endcase
            reg_write(REG_SEED, (phase == 3) ? 32'hFFFF_FFFF : $urandom);
            while (sent < 100 + 170 * (phase + 1)) begin
                if ($urandom_range(0, 9) < 8) begin
                    run_generation();
                end else begin
                    repeat ($urandom_range(1, 5))
                        send_item(1'($urandom_range(0, 1)), rand_fitness());
                end
            end
            drain();
        end

        $display("%0d items sent, %0d results checked, %0d generation updates",
                 sent, result_count, gen_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### pbil_optimizer_engine_unit.f
sv/pbil_pkg.sv
sv/pbil_ctrl.sv
sv/pbil_dp.sv
sv/pbil_optimizer_engine_unit.sv
test/pbil_optimizer_engine_checker.sv
test/pbil_optimizer_engine_unit_tb.sv
